### rtl/core/lowest_common_ancestor_lifting_core_defines.svh
// Assertion macros shared by the core RTL.
`ifndef LOWEST_COMMON_ANCESTOR_LIFTING_CORE_DEFINES_SVH
`define LOWEST_COMMON_ANCESTOR_LIFTING_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LCAL_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcal assertion failed");
`define LCAL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcal assertion failed");
`else
`define LCAL_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define LCAL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### rtl/core/lcal_pkg.sv
package lcal_pkg;

  localparam int NODE_W      = 10;
  localparam int NODE_SPAN   = 1 << NODE_W;
  localparam int COUNT_W     = 11;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BUILD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_NODE  = 1'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic [NODE_W-1:0]  ROOT_RESET  = 10'd1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] node_depth;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] node_count;
    logic [NODE_W-1:0]  root_node;
  } cfg_t;

endpackage

### rtl/core/lcal_ram.sv
module lcal_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re0,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic                     re1,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re0) begin
      rdata0 <= mem[raddr0];
    end
    if (re1) begin
      rdata1 <= mem[raddr1];
    end
  end

endmodule

### rtl/core/lcal_front.sv
`include "lowest_common_ancestor_lifting_core_defines.svh"

module lcal_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [lcal_pkg::KIND_W-1:0]   kind,
  input  logic [lcal_pkg::NODE_W-1:0]   node_a,
  input  logic [lcal_pkg::NODE_W-1:0]   node_b,
  input  logic [lcal_pkg::NODE_W-1:0]   node_depth,
  output logic                          q_valid,
  input  logic                          q_pop,
  output lcal_pkg::item_t               q_item
);

  lcal_pkg::item_t                       slots [lcal_pkg::QUEUE_DEPTH];
  logic [lcal_pkg::QUEUE_PTR_W-1:0]      wr_ptr;
  logic [lcal_pkg::QUEUE_PTR_W-1:0]      rd_ptr;
  logic [lcal_pkg::QUEUE_CNT_W-1:0]      count;
  logic [lcal_pkg::QUEUE_CNT_W-1:0]      count_next;
  lcal_pkg::op_t                         op;
  logic                                  keep;
  logic                                  push;

  // unused kind code is dropped here and never reaches the back end
  always_comb begin
    keep = 1'b1;
    op   = lcal_pkg::OP_LOAD;
    unique case (kind)
      lcal_pkg::KIND_LOAD:  op = lcal_pkg::OP_LOAD;
      lcal_pkg::KIND_BUILD: op = lcal_pkg::OP_BUILD;
      lcal_pkg::KIND_QUERY: op = lcal_pkg::OP_QUERY;
      default:              keep = 1'b0;
    endcase
  end

  assign item_ready = (count != lcal_pkg::QUEUE_CNT_W'(lcal_pkg::QUEUE_DEPTH));
  assign push       = item_valid && item_ready && keep;
  assign q_valid    = (count != '0);
  assign q_item     = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + 1'b1;
    end else if (q_pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
    if (push) begin
      slots[wr_ptr] <= '{op: op, node_a: node_a, node_b: node_b, node_depth: node_depth};
    end
  end

  `LCAL_ASSERT_NEXT(a_queue_drain, clk, rst, q_pop && !push, count == $past(count) - 1'b1)

endmodule

### rtl/core/lcal_back.sv
`include "lowest_common_ancestor_lifting_core_defines.svh"

module lcal_back #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lcal_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  input  lcal_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [lcal_pkg::NODE_W-1:0] common_ancestor
);

  localparam int NW       = lcal_pkg::NODE_W;
  localparam int CW       = lcal_pkg::COUNT_W;
  localparam int SLOTS    = (MAX_NODES < lcal_pkg::NODE_SPAN) ? MAX_NODES : lcal_pkg::NODE_SPAN;
  localparam int AW       = $clog2(SLOTS);
  localparam int LW       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int JT_DEPTH = LIFT_LEVELS * (1 << AW);
  localparam int JT_AW    = $clog2(JT_DEPTH);
  localparam logic [LW-1:0] LVL_TOP      = LW'(LIFT_LEVELS - 1);
  localparam logic [LW-1:0] LVL_LAST_SRC = LW'(LIFT_LEVELS - 2);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_BUILD  = 11'b00000000010,
    S_ORDER  = 11'b00000000100,
    S_LIFT   = 11'b00000001000,
    S_LIFTW  = 11'b00000010000,
    S_CMP    = 11'b00000100000,
    S_RAISE  = 11'b00001000000,
    S_RAISEW = 11'b00010000000,
    S_FINAL  = 11'b00100000000,
    S_FINALW = 11'b01000000000,
    S_EMIT   = 11'b10000000000
  } state_t;

  function automatic logic node_ok(input logic [NW-1:0] n);
    return ({1'b0, n} < (NW + 1)'(SLOTS));
  endfunction

  function automatic logic [JT_AW-1:0] jt_addr(input logic [LW-1:0] l, input logic [AW-1:0] idx);
    return JT_AW'({l, idx});
  endfunction

  state_t         state, state_next;
  logic [LW-1:0]  lvl, lvl_next, lvl_up;
  logic [CW-1:0]  u, u_next, build_cnt;
  logic [NW-1:0]  a, a_next, b, b_next, diff, diff_next;
  logic           ok0, ok0_next, ok1, ok1_next;
  logic           s1_valid, s1_valid_next, s2_valid, s2_valid_next;
  logic [AW-1:0]  s1_u, s1_u_next, s2_u, s2_u_next;
  logic           result_valid_next;
  logic [NW-1:0]  result_next;

  logic             jt_we, jt_re0, jt_re1;
  logic [JT_AW-1:0] jt_waddr, jt_ra0, jt_ra1;
  logic [NW-1:0]    jt_wdata, jt_rd0, jt_rd1, jt_rd0m, jt_rd1m;
  logic             dp_we, dp_re0, dp_re1;
  logic [AW-1:0]    dp_waddr, dp_ra0, dp_ra1;
  logic [NW-1:0]    dp_wdata, dp_rd0, dp_rd1, da, db;

  lcal_ram #(.WIDTH(NW), .DEPTH(JT_DEPTH)) u_jump (
    .clk(clk), .we(jt_we), .waddr(jt_waddr), .wdata(jt_wdata),
    .re0(jt_re0), .raddr0(jt_ra0), .rdata0(jt_rd0),
    .re1(jt_re1), .raddr1(jt_ra1), .rdata1(jt_rd1)
  );

  lcal_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_depth (
    .clk(clk), .we(dp_we), .waddr(dp_waddr), .wdata(dp_wdata),
    .re0(dp_re0), .raddr0(dp_ra0), .rdata0(dp_rd0),
    .re1(dp_re1), .raddr1(dp_ra1), .rdata1(dp_rd1)
  );

  // nodes outside the store read as zero
  assign jt_rd0m   = ok0 ? jt_rd0 : '0;
  assign jt_rd1m   = ok1 ? jt_rd1 : '0;
  assign da        = ok0 ? dp_rd0 : '0;
  assign db        = ok1 ? dp_rd1 : '0;
  assign lvl_up    = lvl + 1'b1;
  assign build_cnt = (cfg.node_count > CW'(SLOTS)) ? CW'(SLOTS) : cfg.node_count;

  always_comb begin
    state_next        = state;
    lvl_next          = lvl;
    u_next            = u;
    a_next            = a;
    b_next            = b;
    diff_next         = diff;
    ok0_next          = ok0;
    ok1_next          = ok1;
    s1_valid_next     = 1'b0;
    s1_u_next         = s1_u;
    s2_valid_next     = 1'b0;
    s2_u_next         = s2_u;
    result_valid_next = result_valid && !result_ready;
    result_next       = common_ancestor;
    q_pop             = 1'b0;
    jt_we    = 1'b0;
    jt_waddr = '0;
    jt_wdata = '0;
    jt_re0   = 1'b0;
    jt_ra0   = '0;
    jt_re1   = 1'b0;
    jt_ra1   = '0;
    dp_we    = 1'b0;
    dp_waddr = '0;
    dp_wdata = '0;
    dp_re0   = 1'b0;
    dp_ra0   = '0;
    dp_re1   = 1'b0;
    dp_ra1   = '0;

    // build pipeline: ancestor of ancestor, then write one level up
    if (s1_valid) begin
      jt_re1        = 1'b1;
      jt_ra1        = jt_addr(lvl, jt_rd0[AW-1:0]);
      ok1_next      = node_ok(jt_rd0);
      s2_valid_next = 1'b1;
      s2_u_next     = s1_u;
    end
    if (s2_valid) begin
      jt_we    = 1'b1;
      jt_waddr = jt_addr(lvl_up, s2_u);
      jt_wdata = jt_rd1m;
    end

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            lcal_pkg::OP_LOAD: begin
              if (node_ok(q_item.node_a)) begin
                jt_we    = 1'b1;
                jt_waddr = jt_addr('0, q_item.node_a[AW-1:0]);
                jt_wdata = q_item.node_b;
                dp_we    = 1'b1;
                dp_waddr = q_item.node_a[AW-1:0];
                dp_wdata = q_item.node_depth;
              end
            end
            lcal_pkg::OP_BUILD: begin
              if (node_ok(cfg.root_node)) begin
                jt_we    = 1'b1;
                jt_waddr = jt_addr('0, cfg.root_node[AW-1:0]);
                jt_wdata = cfg.root_node;
              end
              if (LIFT_LEVELS > 1) begin
                state_next = S_BUILD;
                lvl_next   = '0;
                u_next     = '0;
              end
            end
            lcal_pkg::OP_QUERY: begin
              dp_re0     = 1'b1;
              dp_ra0     = q_item.node_a[AW-1:0];
              dp_re1     = 1'b1;
              dp_ra1     = q_item.node_b[AW-1:0];
              ok0_next   = node_ok(q_item.node_a);
              ok1_next   = node_ok(q_item.node_b);
              a_next     = q_item.node_a;
              b_next     = q_item.node_b;
              state_next = S_ORDER;
            end
            default: ;
          endcase
        end
      end
      S_BUILD: begin
        if (u < build_cnt) begin
          jt_re0        = 1'b1;
          jt_ra0        = jt_addr(lvl, u[AW-1:0]);
          s1_valid_next = 1'b1;
          s1_u_next     = u[AW-1:0];
          u_next        = u + 1'b1;
        end else if (!s1_valid && !s2_valid) begin
          if (lvl == LVL_LAST_SRC) begin
            state_next = S_IDLE;
          end else begin
            lvl_next = lvl_up;
            u_next   = '0;
          end
        end
      end
      S_ORDER: begin
        if (db > da) begin
          a_next    = b;
          b_next    = a;
          diff_next = db - da;
        end else begin
          diff_next = da - db;
        end
        lvl_next   = '0;
        state_next = S_LIFT;
      end
      S_LIFT: begin
        if (diff == '0) begin
          state_next = S_CMP;
        end else if (diff[0]) begin
          jt_re0     = 1'b1;
          jt_ra0     = jt_addr(lvl, a[AW-1:0]);
          ok0_next   = node_ok(a);
          state_next = S_LIFTW;
        end else begin
          diff_next = diff >> 1;
          if (lvl == LVL_TOP) begin
            state_next = S_CMP;
          end else begin
            lvl_next = lvl_up;
          end
        end
      end
      S_LIFTW: begin
        a_next    = jt_rd0m;
        diff_next = diff >> 1;
        if (lvl == LVL_TOP) begin
          state_next = S_CMP;
        end else begin
          lvl_next   = lvl_up;
          state_next = S_LIFT;
        end
      end
      S_CMP: begin
        if (a == b) begin
          state_next = S_EMIT;
        end else begin
          lvl_next   = LVL_TOP;
          state_next = S_RAISE;
        end
      end
      S_RAISE: begin
        jt_re0     = 1'b1;
        jt_ra0     = jt_addr(lvl, a[AW-1:0]);
        ok0_next   = node_ok(a);
        jt_re1     = 1'b1;
        jt_ra1     = jt_addr(lvl, b[AW-1:0]);
        ok1_next   = node_ok(b);
        state_next = S_RAISEW;
      end
      S_RAISEW: begin
        if (jt_rd0m != jt_rd1m) begin
          a_next = jt_rd0m;
          b_next = jt_rd1m;
        end
        if (lvl == '0) begin
          state_next = S_FINAL;
        end else begin
          lvl_next   = lvl - 1'b1;
          state_next = S_RAISE;
        end
      end
      S_FINAL: begin
        jt_re0     = 1'b1;
        jt_ra0     = jt_addr('0, a[AW-1:0]);
        ok0_next   = node_ok(a);
        state_next = S_FINALW;
      end
      S_FINALW: begin
        a_next     = jt_rd0m;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!result_valid || result_ready) begin
          result_valid_next = 1'b1;
          result_next       = a;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      s1_valid     <= s1_valid_next;
      s2_valid     <= s2_valid_next;
      result_valid <= result_valid_next;
    end
    lvl             <= lvl_next;
    u               <= u_next;
    a               <= a_next;
    b               <= b_next;
    diff            <= diff_next;
    ok0             <= ok0_next;
    ok1             <= ok1_next;
    s1_u            <= s1_u_next;
    s2_u            <= s2_u_next;
    common_ancestor <= result_next;
  end

  `LCAL_ASSERT_IMPLY(a_pipe_in_build, clk, rst, s1_valid || s2_valid, state == S_BUILD)
  `LCAL_ASSERT_IMPLY(a_raise_apart, clk, rst, state == S_RAISE, a != b)

endmodule

### rtl/core/lowest_common_ancestor_lifting_core.sv
// Channel   Handshake                   Payload
// item      item_valid / item_ready     kind, node_a, node_b, node_depth
// result    result_valid / result_ready common_ancestor
// config    cfg_write                   cfg_index, cfg_data
//
// Build: one slot per cycle through the jump table's two read ports, for each of the
// LIFT_LEVELS-1 upper levels. Query: two registered table reads per lifting level. A
// two-entry queue takes items while the back end works; a held result stalls only the
// next query's hand-off. Reset restores control and config defaults only; tables are
// undefined until written.
module lowest_common_ancestor_lifting_core #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lcal_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcal_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [lcal_pkg::KIND_W-1:0]     kind,
  input  logic [lcal_pkg::NODE_W-1:0]     node_a,
  input  logic [lcal_pkg::NODE_W-1:0]     node_b,
  input  logic [lcal_pkg::NODE_W-1:0]     node_depth,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [lcal_pkg::NODE_W-1:0]     common_ancestor
);

  lcal_pkg::cfg_t  cfg;
  logic            q_valid;
  logic            q_pop;
  lcal_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_count <= lcal_pkg::COUNT_RESET;
      cfg.root_node  <= lcal_pkg::ROOT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lcal_pkg::REG_NODE_COUNT: cfg.node_count <= cfg_data;
        lcal_pkg::REG_ROOT_NODE:  cfg.root_node  <= cfg_data[lcal_pkg::NODE_W-1:0];
        default: ;
      endcase
    end
  end

  lcal_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .kind       (kind),
    .node_a     (node_a),
    .node_b     (node_b),
    .node_depth (node_depth),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item)
  );

  lcal_back #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .common_ancestor (common_ancestor)
  );

endmodule

### bench/lowest_common_ancestor_lifting_core_tb.sv
module lowest_common_ancestor_lifting_core_tb;
  import lcal_pkg::*;

  localparam int LEVELS = 10;
  localparam int STALL_LIMIT = 100000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [NODE_W-1:0] d;
  } req_t;

  typedef struct packed {
    req_t              req;
    logic              typed;
    logic [NODE_W-1:0] want;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  logic [KIND_W-1:0]     kind = '0;
  logic [NODE_W-1:0]     node_a = '0;
  logic [NODE_W-1:0]     node_b = '0;
  logic [NODE_W-1:0]     node_depth = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic [NODE_W-1:0]     common_ancestor;

  // predictor state
  logic [NODE_W-1:0]  lift_tab [LEVELS][NODE_SPAN];
  logic [NODE_W-1:0]  depth_tab [NODE_SPAN];
  logic [COUNT_W-1:0] span_cfg = COUNT_RESET;
  logic [NODE_W-1:0]  root_cfg = ROOT_RESET;
  logic [NODE_W-1:0]  pending_ancestors [$];

  int          fail_cnt = 0;
  int unsigned offered = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned gap_by_mode [4] = '{0, 50, 0, 8};
  int unsigned stall_by_mode [4] = '{0, 0, 50, 8};

  int plan_count [6] = '{1, 2047, 16, 60, 5, 1024};
  int plan_root [6] = '{0, 1023, -1, -1, -1, -1};
  int plan_tree [6] = '{1, 1024, 16, 60, 5, 0};
  int plan_mix [6] = '{10, 30, 20, 20, 10, 30};

  // small tree under root 1: 1 -> {0, 2}, 0 -> {3, 4}, 2 -> 5, 3 -> 6 -> 7, 7 -> 1023
  step_t script [24] = '{
    '{'{KIND_LOAD,  10'd1,    10'd1023, 10'd0},    1'b0, 10'd0},
    '{'{KIND_LOAD,  10'd0,    10'd1,    10'd1},    1'b0, 10'd0},
    '{'{KIND_LOAD,  10'd2,    10'd1,    10'd1},    1'b0, 10'd0},
    '{'{KIND_LOAD,  10'd3,    10'd0,    10'd2},    1'b0, 10'd0},
    '{'{KIND_LOAD,  10'd4,    10'd0,    10'd2},    1'b0, 10'd0},
    '{'{KIND_LOAD,  10'd5,    10'd2,    10'd2},    1'b0, 10'd0},
    '{'{KIND_LOAD,  10'd6,    10'd3,    10'd3},    1'b0, 10'd0},
    '{'{KIND_LOAD,  10'd7,    10'd6,    10'd4},    1'b0, 10'd0},
    '{'{KIND_LOAD,  10'd1023, 10'd7,    10'd1023}, 1'b0, 10'd0},
    '{'{KIND_QUERY, 10'd0,    10'd1,    10'd0},    1'b1, 10'd1},
    '{'{KIND_QUERY, 10'd3,    10'd0,    10'd0},    1'b1, 10'd0},
    '{'{KIND_QUERY, 10'd1023, 10'd1023, 10'd0},    1'b1, 10'd1023},
    '{'{KIND_UNUSED, 10'd1023, 10'd1023, 10'd1023}, 1'b0, 10'd0},
    '{'{KIND_BUILD, 10'd0,    10'd0,    10'd0},    1'b0, 10'd0},
    '{'{KIND_QUERY, 10'd6,    10'd4,    10'd0},    1'b1, 10'd0},
    '{'{KIND_QUERY, 10'd7,    10'd5,    10'd0},    1'b1, 10'd1},
    '{'{KIND_QUERY, 10'd5,    10'd7,    10'd0},    1'b1, 10'd1},
    '{'{KIND_QUERY, 10'd7,    10'd7,    10'd0},    1'b1, 10'd7},
    '{'{KIND_QUERY, 10'd1,    10'd7,    10'd0},    1'b1, 10'd1},
    '{'{KIND_QUERY, 10'd1023, 10'd4,    10'd0},    1'b0, 10'd0},
    '{'{KIND_LOAD,  10'd5,    10'd6,    10'd4},    1'b0, 10'd0},
    '{'{KIND_QUERY, 10'd5,    10'd7,    10'd0},    1'b0, 10'd0},
    '{'{KIND_QUERY, 10'd0,    10'd0,    10'd0},    1'b1, 10'd0},
    '{'{KIND_QUERY, 10'd1023, 10'd1,    10'd0},    1'b0, 10'd0}
  };

  lowest_common_ancestor_lifting_core #(
    .MAX_NODES(NODE_SPAN),
    .LIFT_LEVELS(LEVELS)
  ) i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int cover_span();
    return (span_cfg > NODE_SPAN) ? NODE_SPAN : int'(span_cfg);
  endfunction

  function automatic logic [NODE_W-1:0] one_deeper(logic [NODE_W-1:0] up);
    return (depth_tab[up] == '1) ? '1 : depth_tab[up] + 1'b1;
  endfunction

  function automatic void rebuild_lifts();
    int lim;
    lim = cover_span();
    lift_tab[0][root_cfg] = root_cfg;
    for (int l = 1; l < LEVELS; l++)
      for (int u = 0; u < lim; u++)
        lift_tab[l][u] = lift_tab[l-1][lift_tab[l-1][u]];
  endfunction

  function automatic logic [NODE_W-1:0] lowest_shared(logic [NODE_W-1:0] x,
                                                      logic [NODE_W-1:0] y);
    logic [NODE_W-1:0] t;
    logic [NODE_W-1:0] dx;
    logic [NODE_W-1:0] dy;
    logic [NODE_W-1:0] gap;
    dx = depth_tab[x];
    dy = depth_tab[y];
    if (dy > dx) begin
      t = x; x = y; y = t;
      t = dx; dx = dy; dy = t;
    end
    gap = dx - dy;
    for (int l = 0; l < LEVELS; l++)
      if (gap[l]) x = lift_tab[l][x];
    if (x == y) return x;
    for (int l = LEVELS - 1; l >= 0; l--)
      if (lift_tab[l][x] != lift_tab[l][y]) begin
        x = lift_tab[l][x];
        y = lift_tab[l][y];
      end
    return lift_tab[0][x];
  endfunction

  function automatic logic [NODE_W-1:0] absorb(req_t req);
    case (req.kind)
      KIND_LOAD: begin
        lift_tab[0][req.a] = req.b;
        depth_tab[req.a] = req.d;
      end
      KIND_BUILD: rebuild_lifts();
      default: ;
    endcase
    return (req.kind == KIND_QUERY) ? lowest_shared(req.a, req.b) : '0;
  endfunction

  function automatic logic [NODE_W-1:0] any_node(int lim, bit anywhere);
    if (anywhere && $urandom_range(99) < 15) return NODE_W'($urandom);
    return NODE_W'($urandom_range(lim - 1));
  endfunction

  task automatic offer(input req_t req, input logic typed, input logic [NODE_W-1:0] want);
    logic [NODE_W-1:0] guess;
    send_gap_pct = gap_by_mode[(offered / 50) % 4];
    stall_pct = stall_by_mode[(offered / 50) % 4];
    offered++;
    while ($urandom_range(99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= req.kind;
    node_a <= req.a;
    node_b <= req.b;
    node_depth <= req.d;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    guess = absorb(req);
    if (req.kind == KIND_QUERY) pending_ancestors = {pending_ancestors, (typed ? want : guess)};
  endtask

  task automatic set_config(input logic [COUNT_W-1:0] count, input logic [NODE_W-1:0] root,
                            input bit with_root);
    cfg_write <= 1'b1;
    cfg_index <= REG_NODE_COUNT;
    cfg_data <= count;
    span_cfg = count;
    @(posedge clk);
    if (with_root) begin
      cfg_index <= REG_ROOT_NODE;
      cfg_data <= CFG_DATA_W'(root);
      root_cfg = root;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // long: also cover builds still running after the last result
  task automatic settle_down(input bit long);
    item_valid <= 1'b0;
    while (pending_ancestors.size() != 0) @(posedge clk);
    if (long) repeat (3 * (1 + (LEVELS - 1) * (cover_span() + 3)) + 64) @(posedge clk);
  endtask

  task automatic plant_tree(input int lim);
    logic [NODE_W-1:0] order [NODE_SPAN];
    logic [NODE_W-1:0] held;
    int fill;
    int j;
    req_t req;
    order[0] = root_cfg;
    fill = 1;
    for (int u = 0; u < lim; u++)
      if (u != root_cfg) begin
        order[fill] = NODE_W'(u);
        fill++;
      end
    for (int i = lim - 1; i > 1; i--) begin
      j = $urandom_range(i, 1);
      held = order[i];
      order[i] = order[j];
      order[j] = held;
    end
    for (int i = 0; i < lim; i++) begin
      req.kind = KIND_LOAD;
      req.a = order[i];
      if (i == 0) begin
        req.b = NODE_W'($urandom);
        req.d = '0;
      end else begin
        // bias toward chains for deep trees
        req.b = ($urandom_range(1) == 1) ? order[i-1] : order[$urandom_range(i - 1)];
        req.d = one_deeper(req.b);
      end
      offer(req, 1'b0, '0);
    end
    req = '0;
    req.kind = KIND_BUILD;
    offer(req, 1'b0, '0);
  endtask

  task automatic random_item(input int lim, input bit anywhere);
    req_t req;
    int pick;
    pick = $urandom_range(99);
    req.kind = KIND_QUERY;
    req.a = any_node(lim, anywhere);
    req.b = any_node(lim, anywhere);
    req.d = NODE_W'($urandom);
    if (pick >= 60 && pick < 85) begin
      req.kind = KIND_LOAD;
      if ($urandom_range(99) < 70) req.d = one_deeper(req.b);
    end else if (pick >= 85 && pick < 92) begin
      // full-size builds are slow, keep them rare
      if (lim <= 128 || $urandom_range(4) == 0) req.kind = KIND_BUILD;
    end else if (pick >= 92) begin
      req.kind = KIND_UNUSED;
    end
    offer(req, 1'b0, '0);
  endtask

  always @(posedge clk) begin : result_check
    logic [NODE_W-1:0] want;
    if (!rst && result_valid && result_ready) begin
      if (pending_ancestors.size() == 0) begin
        $error("common_ancestor: expected none, got %0d", common_ancestor);
        fail_cnt++;
      end else begin
        want = pending_ancestors.pop_front();
        if (common_ancestor !== want) begin
          $error("common_ancestor: expected %0d, got %0d", want, common_ancestor);
          fail_cnt++;
        end
      end
    end
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  // no transfer for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int lim;
    int root_pick;
    bit all_written;
    all_written = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // root keeps its reset value here
    set_config(11'd8, ROOT_RESET, 1'b0);
    foreach (script[i]) offer(script[i].req, script[i].typed, script[i].want);
    for (int p = 0; p < 6; p++) begin
      settle_down(1'b1);
      lim = (plan_count[p] > NODE_SPAN) ? NODE_SPAN : plan_count[p];
      root_pick = (plan_root[p] < 0) ? $urandom_range(lim - 1) : plan_root[p];
      set_config(COUNT_W'(plan_count[p]), NODE_W'(root_pick), 1'b1);
      if (plan_tree[p] > 0) plant_tree(plan_tree[p]);
      // every slot and level is written once a full-size tree is built
      if (lim == NODE_SPAN) all_written = 1'b1;
      for (int n = 0; n < plan_mix[p]; n++) begin
        if (n == plan_mix[p] / 2) settle_down(1'b0);
        random_item(lim, all_written);
      end
    end
    settle_down(1'b1);
    if (fail_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
